>>> hw/rtl/trt_pkg.sv
// Shared types, register indexes and helper functions for the token
// reputation table. No dependencies.
package trt_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam int CNT_W      = 40;
  localparam int HIST_W     = 8;

  localparam logic [HIST_W-1:0] HIST_RESET = 8'h55;
  localparam logic [16:0]       VOCAB_RESET  = 17'd65536;
  localparam logic [15:0]       PERIOD_RESET = 16'd500;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOCAB_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_PERIOD = 1'b1;

  // Operation codes
  localparam logic OP_COMMIT = 1'b0;
  localparam logic OP_ADJUST = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic clear_en;
    logic exec_en;
    logic sweep_start;
    logic sweep_en;
    logic finish;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_done;
    logic sweep_req;
    logic sweep_done;
  } status_t;

  function automatic logic [3:0] pop8(input logic [HIST_W-1:0] v);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < HIST_W; i++) begin
      c = c + 4'(v[i]);
    end
    return c;
  endfunction

  // Strip the highest set bit of a near-full history, or fill the highest
  // clear bit of a near-empty one.
  function automatic logic [HIST_W-1:0] decay8(input logic [HIST_W-1:0] r);
    logic [3:0]        s;
    logic [HIST_W-1:0] res;
    logic              hit;
    s   = pop8(r);
    res = r;
    hit = 1'b0;
    for (int b = HIST_W - 1; b >= 0; b--) begin
      if (!hit && s >= 4'd7 && r[b]) begin
        res[b] = 1'b0;
        hit    = 1'b1;
      end else if (!hit && s <= 4'd1 && !r[b]) begin
        res[b] = 1'b1;
        hit    = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/trt_ctrl.sv
// Controller state machine for the token reputation table: clearing pass,
// request intake, execute and decay sweep sequencing. Depends on trt_pkg.
module trt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  trt_pkg::status_t  status,
  output trt_pkg::cmd_t     cmd,
  output logic              busy
);
  import trt_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec_en = 1'b1;
        if (status.sweep_req) begin
          cmd.sweep_start = 1'b1;
          state_next      = ST_SWEEP;
        end else begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_en = 1'b1;
        if (status.sweep_done) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

>>> hw/rtl/trt_datapath.sv
// Datapath for the token reputation table: history memory, config
// registers, commit counters, sweep engine and result registers.
// Depends on trt_pkg.
module trt_datapath #(
  parameter int VOCAB_MAX = 65536
) (
  input  logic                              clk,
  input  logic                              rst,
  input  trt_pkg::cmd_t                     cmd,
  output trt_pkg::status_t                  status,
  input  logic                              cfg_we,
  input  logic [trt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              op,
  input  logic [15:0]                       tok_idx,
  input  logic signed [15:0]                sigma_pre,
  input  logic signed [15:0]                sigma_post,
  input  logic signed [31:0]                logit_in,
  input  logic                              batch_last,
  output logic                              done,
  output logic signed [31:0]                logit_out,
  output logic [3:0]                        rep_score,
  output logic                              id_valid,
  output logic                              decay_swept,
  output logic [trt_pkg::CNT_W-1:0]         total_count,
  output logic [trt_pkg::CNT_W-1:0]         coherent_count,
  output logic [trt_pkg::CNT_W-1:0]         incoherent_count,
  output logic                              batch_end
);
  import trt_pkg::*;

  localparam int AW = (VOCAB_MAX > 1) ? $clog2(VOCAB_MAX) : 1;
  localparam int CW = (AW + 1 > 17) ? AW + 1 : 17;
  localparam logic [CW-1:0] VMAX_W  = CW'(VOCAB_MAX);
  localparam logic [AW-1:0] LAST_AD = AW'(VOCAB_MAX - 1);

  // History memory
  logic [HIST_W-1:0] mem [VOCAB_MAX];
  logic [HIST_W-1:0] rd;
  logic [AW-1:0]     ra;
  logic              we;
  logic [AW-1:0]     wa;
  logic [HIST_W-1:0] wd;

  // Config registers
  logic [16:0] vocab_size;
  logic [15:0] decay_period;

  // Request registers
  logic              op_q;
  logic [AW-1:0]     id_q;
  logic              coh_q;
  logic signed [31:0] logit_q;
  logic              last_q;
  logic              valid_q;

  // Counters and sweep engine
  logic [CNT_W-1:0] tot, coh, inc;
  logic [15:0]      phase;
  logic [AW-1:0]    clr;
  logic [CW-1:0]    rc;
  logic             pv;
  logic [AW-1:0]    pa;

  logic [CW-1:0]      nv;
  logic [CW-1:0]      id_w;
  logic               id_ok;
  logic               commit;
  logic [HIST_W-1:0]  h;
  logic [15:0]        phase_inc;
  logic [15:0]        period_eff;
  logic               sweep_hit;
  logic               rc_live;
  logic [3:0]         score_rd;
  logic signed [4:0]  rel;
  logic signed [33:0] sum;
  logic signed [31:0] sat;

  // Effective vocabulary and id check
  assign nv    = (CW'(vocab_size) > VMAX_W) ? VMAX_W : CW'(vocab_size);
  assign id_w  = CW'(tok_idx);
  assign id_ok = (id_w < nv);

  // Execute step
  assign commit     = valid_q && (op_q == OP_COMMIT);
  assign h          = {rd[HIST_W-2:0], coh_q};
  assign phase_inc  = phase + 16'd1;
  assign period_eff = (decay_period == 16'd0) ? 16'd1 : decay_period;
  assign sweep_hit  = commit && ((phase_inc >= period_eff) || (phase_inc == 16'd0));
  assign score_rd   = pop8(rd);
  assign rel        = $signed({1'b0, score_rd}) - 5'sd4;
  assign sum        = 34'(logit_q) + {{14{rel[4]}}, rel, 15'd0};
  always_comb begin
    priority if (sum > 34'sd2147483647) begin
      sat = 32'sh7FFF_FFFF;
    end else if (sum < -34'sd2147483648) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = sum[31:0];
    end
  end

  assign rc_live = (rc < nv);

  // Memory port selection
  assign ra = cmd.accept ? id_w[AW-1:0] : rc[AW-1:0];
  always_comb begin
    we = 1'b0;
    wa = clr;
    wd = HIST_RESET;
    priority if (cmd.clear_en) begin
      we = 1'b1;
    end else if (cmd.exec_en && commit) begin
      we = 1'b1;
      wa = id_q;
      wd = h;
    end else if (cmd.sweep_en && pv) begin
      we = 1'b1;
      wa = pa;
      wd = decay8(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vocab_size   <= VOCAB_RESET;
      decay_period <= PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VOCAB_SIZE:   vocab_size   <= cfg_data;
        REG_DECAY_PERIOD: decay_period <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Capture request fields
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q    <= op;
      id_q    <= id_w[AW-1:0];
      coh_q   <= (sigma_post <= sigma_pre);
      logit_q <= logit_in;
      last_q  <= batch_last;
      valid_q <= id_ok;
    end
  end

  // Clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.clear_en) begin
      clr <= clr + AW'(1);
    end
  end

  // Counters and decay phase
  always_ff @(posedge clk) begin
    if (rst) begin
      tot   <= '0;
      coh   <= '0;
      inc   <= '0;
      phase <= '0;
    end else if (cmd.exec_en && commit) begin
      tot   <= tot + CNT_W'(1);
      phase <= sweep_hit ? 16'd0 : phase_inc;
      if (coh_q) begin
        coh <= coh + CNT_W'(1);
      end else begin
        inc <= inc + CNT_W'(1);
      end
    end
  end

  // Sweep engine: read one entry a cycle, write it back decayed next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rc <= '0;
      pv <= 1'b0;
    end else if (cmd.sweep_start) begin
      rc <= '0;
      pv <= 1'b0;
    end else if (cmd.sweep_en) begin
      pv <= rc_live;
      if (rc_live) begin
        rc <= rc + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pa <= rc[AW-1:0];
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.exec_en) begin
      logit_out   <= (valid_q && op_q == OP_ADJUST) ? sat : logit_q;
      id_valid    <= valid_q;
      decay_swept <= sweep_hit;
      batch_end   <= last_q;
      priority if (!valid_q) begin
        rep_score <= 4'd0;
      end else if (op_q == OP_COMMIT) begin
        rep_score <= sweep_hit ? pop8(decay8(h)) : pop8(h);
      end else begin
        rep_score <= score_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  assign total_count      = tot;
  assign coherent_count   = coh;
  assign incoherent_count = inc;

  assign status.clear_done = (clr == LAST_AD);
  assign status.sweep_req  = sweep_hit;
  assign status.sweep_done = !rc_live && !pv;

endmodule

>>> hw/rtl/token_reputation_table_unit.sv
// Token reputation table: a request is taken when start is high and busy low;
// its result strobes on done in the cycle after the last execute or sweep cycle,
// and busy stays high until the result strobes, so the next request waits for the
// last one to finish. A commit that triggers a decay sweep walks min(vocab_size,
// VOCAB_MAX) entries, one entry per cycle through the history memory. After reset the memory is
// cleared to 0x55 with busy high; counters reset to zero.
module token_reputation_table_unit #(
  parameter int VOCAB_MAX = 65536
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              op,
  input  logic [15:0]                       tok_idx,
  input  logic signed [15:0]                sigma_pre,
  input  logic signed [15:0]                sigma_post,
  input  logic signed [31:0]                logit_in,
  input  logic                              batch_last,
  output logic                              done,
  output logic signed [31:0]                logit_out,
  output logic [3:0]                        rep_score,
  output logic                              id_valid,
  output logic                              decay_swept,
  output logic [trt_pkg::CNT_W-1:0]         total_count,
  output logic [trt_pkg::CNT_W-1:0]         coherent_count,
  output logic [trt_pkg::CNT_W-1:0]         incoherent_count,
  output logic                              batch_end,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [trt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import trt_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  trt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  trt_datapath #(
    .VOCAB_MAX (VOCAB_MAX)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .op               (op),
    .tok_idx          (tok_idx),
    .sigma_pre        (sigma_pre),
    .sigma_post       (sigma_post),
    .logit_in         (logit_in),
    .batch_last       (batch_last),
    .done             (done),
    .logit_out        (logit_out),
    .rep_score        (rep_score),
    .id_valid         (id_valid),
    .decay_swept      (decay_swept),
    .total_count      (total_count),
    .coherent_count   (coherent_count),
    .incoherent_count (incoherent_count),
    .batch_end        (batch_end)
  );

endmodule

>>> hw/rtl/trt_checker.sv
// Port-level checks for the token reputation table, bound to the top level.
// Depends on token_reputation_table_unit.
module trt_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       id_valid,
  input logic       decay_swept,
  input logic [3:0] rep_score
);

  // Busy while clearing after reset
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");

  // A taken request holds off intake next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken without going busy");

  // Result strobe lands when the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Results never come back to back
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe on consecutive cycles");

  // Rejected id gives a bare result
  a_invalid_bare: assert property (@(posedge clk) disable iff (rst)
    (done && !id_valid) |-> (rep_score == 4'd0 && !decay_swept))
    else $error("invalid id carries score or sweep");

endmodule

bind token_reputation_table_unit trt_checker u_trt_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .id_valid    (id_valid),
  .decay_swept (decay_swept),
  .rep_score   (rep_score)
);

>>> dv/tb_top.sv
// Self-checking testbench for token_reputation_table_unit: commits and adjusts
// are checked against a behavioural copy of the history table and counters.
// Depends on trt_pkg (hw/rtl/trt_pkg.sv) and the unit itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import trt_pkg::*;

  localparam int     VOCAB_LIM    = 65536;
  localparam int     SETTLE_LIMIT = 200000;
  localparam longint LOGIT_MAX    = 64'sd2147483647;
  localparam longint LOGIT_MIN    = -64'sd2147483648;

  // Expected content of one result strobe
  typedef struct {
    logic signed [31:0] logit;
    logic [3:0]         score;
    logic               id_ok;
    logic               swept;
    logic [CNT_W-1:0]   total;
    logic [CNT_W-1:0]   coherent;
    logic [CNT_W-1:0]   incoherent;
    logic               last;
  } rep_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  op = OP_COMMIT;
  logic [15:0]           tok_idx = '0;
  logic signed [15:0]    sigma_pre = '0;
  logic signed [15:0]    sigma_post = '0;
  logic signed [31:0]    logit_in = '0;
  logic                  batch_last = 1'b0;
  logic                  done;
  logic signed [31:0]    logit_out;
  logic [3:0]            rep_score;
  logic                  id_valid;
  logic                  decay_swept;
  logic [CNT_W-1:0]      total_count;
  logic [CNT_W-1:0]      coherent_count;
  logic [CNT_W-1:0]      incoherent_count;
  logic                  batch_end;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_VOCAB_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the table, counters and registers
  logic [HIST_W-1:0] hist_mem [VOCAB_LIM];
  logic [CNT_W-1:0]  cnt_total;
  logic [CNT_W-1:0]  cnt_coherent;
  logic [CNT_W-1:0]  cnt_incoherent;
  logic [15:0]       sweep_phase;
  logic [16:0]       vocab_cfg;
  logic [15:0]       period_cfg;

  rep_result_t pending_results[$];
  int          errors = 0;
  int          n_commits = 0;
  int          n_adjusts = 0;
  int          n_invalid = 0;
  int          n_sweeps = 0;
  bit          no_idle = 1'b0;

  token_reputation_table_unit DUT (.*);

  always #10 clk = ~clk;

  // Hard stop well beyond the slowest legal run (clear pass, two full sweeps)
  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic reset_shadow();
    for (int i = 0; i < VOCAB_LIM; i++) begin
      hist_mem[16'(i)] = HIST_RESET;
    end
    cnt_total      = '0;
    cnt_coherent   = '0;
    cnt_incoherent = '0;
    sweep_phase    = '0;
    vocab_cfg      = VOCAB_RESET;
    period_cfg     = PERIOD_RESET;
  endtask

  function automatic int unsigned live_entries();
    return (vocab_cfg > 17'd65536) ? 32'd65536 : 32'(vocab_cfg);
  endfunction

  // Clear the top set bit of a near-full history, set the top clear bit of a
  // near-empty one, leave the rest alone.
  function automatic logic [HIST_W-1:0] fade_entry(input logic [HIST_W-1:0] e);
    int                ones;
    logic [HIST_W-1:0] bit_mask;
    ones = $countones(e);
    for (int b = HIST_W - 1; b >= 0; b--) begin
      bit_mask = '0;
      bit_mask[b] = 1'b1;
      if (ones >= 7 && e[b]) return e & ~bit_mask;
      if (ones <= 1 && !e[b]) return e | bit_mask;
    end
    return e;
  endfunction

  // Apply one accepted request to the shadow and queue its expected result
  task automatic predict_reputation(input logic o, input logic [15:0] id,
                                    input logic signed [15:0] sb,
                                    input logic signed [15:0] sa,
                                    input logic signed [31:0] lg, input logic bl);
    rep_result_t       r;
    int unsigned       nv;
    int unsigned       per;
    logic [HIST_W-1:0] h;
    longint            sum;
    nv      = live_entries();
    r.logit = lg;
    r.score = '0;
    r.id_ok = (32'(id) < nv);
    r.swept = 1'b0;
    r.last  = bl;
    if (!r.id_ok) n_invalid++;
    if (r.id_ok && o == OP_COMMIT) begin
      h   = {hist_mem[id][HIST_W-2:0], 1'b0};
      per = (period_cfg == 16'd0) ? 32'd1 : 32'(period_cfg);
      if (sa <= sb) begin
        h[0] = 1'b1;
        cnt_coherent = cnt_coherent + 1'b1;
      end else begin
        cnt_incoherent = cnt_incoherent + 1'b1;
      end
      hist_mem[id] = h;
      cnt_total    = cnt_total + 1'b1;
      sweep_phase  = sweep_phase + 1'b1;
      if (32'(sweep_phase) >= per || sweep_phase == 16'd0) begin
        sweep_phase = '0;
        r.swept     = 1'b1;
        n_sweeps++;
        for (int unsigned i = 0; i < nv; i++) begin
          hist_mem[16'(i)] = fade_entry(hist_mem[16'(i)]);
        end
      end
      r.score = 4'($countones(hist_mem[id]));
    end else if (r.id_ok) begin
      r.score = 4'($countones(hist_mem[id]));
      // (score - 4) * 0.5 in Q16.16, saturated to 32 bits
      sum = longint'(lg) + (longint'(r.score) - 4) * 32768;
      if (sum > LOGIT_MAX) sum = LOGIT_MAX;
      if (sum < LOGIT_MIN) sum = LOGIT_MIN;
      r.logit = sum[31:0];
    end
    r.total      = cnt_total;
    r.coherent   = cnt_coherent;
    r.incoherent = cnt_incoherent;
    pending_results.push_back(r);
  endtask

  // Send one request, then drop start for a random idle gap, which may be empty and is skipped when no_idle is set
  task automatic issue(input logic o, input logic [15:0] id,
                       input logic signed [15:0] sb, input logic signed [15:0] sa,
                       input logic signed [31:0] lg, input logic bl);
    int gap;
    op         <= o;
    tok_idx    <= id;
    sigma_pre  <= sb;
    sigma_post <= sa;
    logit_in   <= lg;
    batch_last <= bl;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    if (o == OP_COMMIT) n_commits++;
    else n_adjusts++;
    predict_reputation(o, id, sb, sa, lg, bl);
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every expected result has arrived or SETTLE_LIMIT runs out, then let the unit drain
  task automatic settle();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_results.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors += pending_results.size();
      pending_results.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_VOCAB_SIZE) vocab_cfg = val;
    else period_cfg = val[15:0];
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_id();
    int unsigned nv;
    int unsigned roll;
    nv   = live_entries();
    roll = $urandom_range(0, 7);
    if (nv == 0 || roll == 0) return 16'($urandom());
    if (roll == 1) return (nv < 65536) ? 16'(nv) : 16'(nv - 1);
    return 16'($urandom_range(0, nv - 1));
  endfunction

  function automatic logic signed [31:0] pick_logit();
    case ($urandom_range(0, 3))
      0: return 32'sh7FFF_0000 | 32'($urandom_range(0, 65535));
      1: return 32'sh8000_0000 | 32'($urandom_range(0, 65535));
      default: return $urandom();
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                      input logic [CNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare every result strobe with the oldest expectation
  always @(posedge clk) begin
    rep_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, logit_out %h rep_score %0d",
                 $time, logit_out, rep_score);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("logit_out", CNT_W'({want.logit}), CNT_W'({logit_out}));
        check_field("rep_score", CNT_W'(want.score), CNT_W'(rep_score));
        check_field("id_valid", CNT_W'(want.id_ok), CNT_W'(id_valid));
        check_field("decay_swept", CNT_W'(want.swept), CNT_W'(decay_swept));
        check_field("total_count", want.total, total_count);
        check_field("coherent_count", want.coherent, coherent_count);
        check_field("incoherent_count", want.incoherent, incoherent_count);
        check_field("batch_end", CNT_W'(want.last), CNT_W'(batch_end));
      end
    end
  end

  // Reset state, sigma extremes, table ends, saturation in both directions
  task automatic test_reset_state();
    issue(OP_ADJUST, 16'd0, 16'sd0, 16'sd0, 32'sd0, 1'b0);
    issue(OP_ADJUST, 16'hFFFF, 16'sd0, 16'sd0, -32'sd1, 1'b1);
    issue(OP_COMMIT, 16'd0, -16'sd32768, 16'sd32767, 32'sd7, 1'b0);
    issue(OP_COMMIT, 16'd0, 16'sd32767, -16'sd32768, 32'sd7, 1'b1);
    issue(OP_COMMIT, 16'hFFFF, 16'sd100, 16'sd100, 32'sd0, 1'b0);
    // push entry 5 up to seven ones, entry 6 down to one
    repeat (5) issue(OP_COMMIT, 16'd5, 16'sd5, -16'sd3, 32'sd0, 1'b0);
    repeat (6) issue(OP_COMMIT, 16'd6, -16'sd1, 16'sd0, 32'sd0, 1'b0);
    issue(OP_ADJUST, 16'd5, 16'sd0, 16'sd0, 32'sh7FFF_FFFF, 1'b0);
    issue(OP_ADJUST, 16'd6, 16'sd0, 16'sd0, 32'sh8000_0000, 1'b0);
    issue(OP_ADJUST, 16'd5, 16'sd0, 16'sd0, 32'sh8000_0000, 1'b1);
  endtask

  // Oversized and zero vocabulary, period lowered below phase, full sweep
  task automatic test_register_edges();
    settle();
    write_reg(REG_VOCAB_SIZE, 17'h1FFFF);
    write_reg(REG_DECAY_PERIOD, 17'd1);
    issue(OP_COMMIT, 16'd7, 16'sd0, 16'sd0, 32'sd0, 1'b0);
    issue(OP_ADJUST, 16'd5, 16'sd0, 16'sd0, 32'sd0, 1'b0);
    issue(OP_ADJUST, 16'd6, 16'sd0, 16'sd0, 32'sd0, 1'b1);
    settle();
    write_reg(REG_VOCAB_SIZE, 17'd0);
    issue(OP_COMMIT, 16'd0, 16'sd0, 16'sd0, 32'sd9, 1'b0);
    issue(OP_ADJUST, 16'd0, 16'sd0, 16'sd0, 32'sd9, 1'b1);
    settle();
    write_reg(REG_VOCAB_SIZE, 17'd1);
    write_reg(REG_DECAY_PERIOD, 17'h10002);
    issue(OP_COMMIT, 16'd0, 16'sd1, 16'sd1, 32'sd0, 1'b0);
    issue(OP_COMMIT, 16'd1, 16'sd1, 16'sd1, 32'sd0, 1'b0);
    issue(OP_COMMIT, 16'd0, 16'sd1, 16'sd2, 32'sd0, 1'b0);
    issue(OP_ADJUST, 16'hFFFF, 16'sd0, 16'sd0, 32'sd3, 1'b1);
  endtask

  // Mixed commits and adjust batches over a range of register settings
  task automatic test_random_traffic();
    logic [16:0]        vocab;
    logic [15:0]        per;
    logic signed [15:0] sb;
    logic signed [15:0] sa;
    int                 sent;
    int                 len;
    for (int ph = 0; ph < 7; ph++) begin
      settle();
      case (ph)
        0: begin vocab = 17'd1; per = 16'd0; end
        1: begin vocab = 17'd2; per = 16'd1; end
        2: begin vocab = 17'($urandom_range(3, 64)); per = 16'($urandom_range(2, 40)); end
        3: begin vocab = VOCAB_RESET; per = 16'hFFFF; end
        4: begin vocab = 17'($urandom_range(3, 64)); per = 16'($urandom_range(1, 8)); end
        5: begin vocab = 17'd16; per = 16'd3; end
        default: begin
          vocab = 17'($urandom_range(1, 64));
          per   = 16'($urandom_range(1, 64));
        end
      endcase
      write_reg(REG_VOCAB_SIZE, vocab);
      write_reg(REG_DECAY_PERIOD, {1'($urandom_range(0, 1)), per});
      no_idle = (ph % 3 == 1);
      sent = 0;
      while (sent < 100) begin
        if (sent == 50) settle();
        if ($urandom_range(0, 1) == 1) begin
          // adjust batch, last row flagged
          len = $urandom_range(1, 6);
          for (int j = 0; j < len; j++) begin
            issue(OP_ADJUST, pick_id(), 16'($urandom()), 16'($urandom()), pick_logit(),
                  j == len - 1);
            sent++;
          end
        end else begin
          sb = 16'($urandom());
          sa = ($urandom_range(0, 3) == 0) ? sb : 16'($urandom());
          issue(OP_COMMIT, pick_id(), sb, sa, pick_logit(), 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    reset_shadow();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_register_edges();
    test_random_traffic();
    settle();
    $display("Covered %0d commits and %0d adjusts, %0d with out-of-range ids,",
             n_commits, n_adjusts, n_invalid);
    $display("and %0d decay sweeps over vocabularies from 0 to beyond the table.", n_sweeps);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/trt_pkg.sv
hw/rtl/trt_ctrl.sv
hw/rtl/trt_datapath.sv
hw/rtl/token_reputation_table_unit.sv
hw/rtl/trt_checker.sv
dv/tb_top.sv
